// ===== design/fmp_pkg.sv =====
// fmp_pkg: shared widths, reset value and request/response types for the
// fibonacci modulo block and its modular multiplier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fmp_pkg;

  // modulus and value width
  localparam int MOD_BITS = 31;
  // output tdata width, value padded to whole bytes
  localparam int OUT_TDATA_BITS = ((MOD_BITS + 7) / 8) * 8;
  // default index width
  localparam int INDEX_BITS_DEFAULT = 62;
  // modulus after reset
  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(111539786);

  // request into the modular multiplier
  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
  } mul_req_t;

  // response from the modular multiplier
  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] result;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== design/fmp_modmul.sv =====
// fmp_modmul: bit-serial interleaved modular multiplier, a * b mod m,
// one bit of b per cycle from the top; uses fmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmp_modmul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [fmp_pkg::MOD_BITS-1:0]  modulus,
  input  wire fmp_pkg::mul_req_t             req,
  output fmp_pkg::mul_rsp_t                  rsp
);
  import fmp_pkg::*;

  localparam int CNT_W = $clog2(MOD_BITS);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic                done;

  logic [MOD_BITS+1:0] sum;
  logic [MOD_BITS+1:0] m_x1;
  logic [MOD_BITS+1:0] m_x2;
  logic [MOD_BITS-1:0] acc_next;

  // one step: 2*acc + bit*a stays below 3m, take off 0, m or 2m
  always_comb begin
    m_x1 = {2'b00, modulus};
    m_x2 = {1'b0, modulus, 1'b0};
    sum  = {1'b0, acc, 1'b0} + (b_r[cnt] ? {2'b00, a_r} : '0);
    if (sum >= m_x2) begin
      acc_next = MOD_BITS'(sum - m_x2);
    end else if (sum >= m_x1) begin
      acc_next = MOD_BITS'(sum - m_x1);
    end else begin
      acc_next = MOD_BITS'(sum);
    end
  end

  // bit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        acc <= acc_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end else if (req.start) begin
        a_r  <= req.a;
        b_r  <= req.b;
        acc  <= '0;
        cnt  <= CNT_W'(MOD_BITS - 1);
        busy <= 1'b1;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

`default_nettype wire

// ===== design/fibonacci_mod_matrix_power_unit.sv =====
// fibonacci_mod_matrix_power_unit: F(index+1) mod modulus by fast doubling
// over the exponent bits; uses fmp_pkg and fmp_modmul
//
//   channel   dir  beat fields (low bit first)
//   s_axis    in   tdata: index
//   m_axis    out  tdata: fib_value
//   cfg       in   cfg_wr_data: modulus (write-only, no handshake)
//
// one item at a time: the leading zeros of the 63-bit index+1 are skipped in
// S_BIT, then each remaining bit takes three multiplications on the shared
// bit-serial multiplier plus five steps, and S_DONE loads the result; a
// modulus below two goes straight to S_DONE and answers zero.
// rst is synchronous and restores the modulus to its reset value.
// a held result stalls the sequencer at its end; s_axis_tready is high only
// while idle.
`timescale 1ns / 1ps
`default_nettype none

module fibonacci_mod_matrix_power_unit #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // cfg_wr_data: modulus
  input  wire logic                                  cfg_wr_en,
  input  wire logic [fmp_pkg::MOD_BITS-1:0]          cfg_wr_data,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // s_axis_tdata: index, zero padded
  input  wire logic [((INDEX_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // m_axis_tdata: fib_value, zero padded
  output logic [fmp_pkg::OUT_TDATA_BITS-1:0]         m_axis_tdata
);
  import fmp_pkg::*;

  localparam int KBITS = INDEX_BITS + 1;
  localparam int POS_W = $clog2(KBITS);

  typedef enum logic [3:0] {
    S_IDLE, S_BIT, S_DBL, S_SUB, S_MUL_C, S_MUL_P, S_MUL_Q, S_ADD, S_UPD, S_DONE
  } state_t;

  state_t              state;
  logic [MOD_BITS-1:0] modulus;
  logic [KBITS-1:0]    k;
  logic [POS_W-1:0]    pos;
  logic [MOD_BITS-1:0] fa;      // F(j) mod m
  logic [MOD_BITS-1:0] fb;      // F(j+1) mod m
  logic [MOD_BITS-1:0] t;
  logic [MOD_BITS-1:0] c;
  logic [MOD_BITS-1:0] sq_a;
  logic [MOD_BITS-1:0] sq_b;
  logic                launched;
  logic                out_valid;
  logic [MOD_BITS-1:0] out_data;

  mul_req_t            mreq;
  mul_rsp_t            mrsp;

  // modular add of two values below m
  function automatic logic [MOD_BITS-1:0] mod_add(
    input logic [MOD_BITS-1:0] x,
    input logic [MOD_BITS-1:0] y,
    input logic [MOD_BITS-1:0] m
  );
    logic [MOD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return MOD_BITS'(s);
  endfunction

  // modular subtract of two values below m
  function automatic logic [MOD_BITS-1:0] mod_sub(
    input logic [MOD_BITS-1:0] x,
    input logic [MOD_BITS-1:0] y,
    input logic [MOD_BITS-1:0] m
  );
    logic [MOD_BITS:0] s;
    if (x >= y) begin
      s = {1'b0, x} - {1'b0, y};
    end else begin
      s = {1'b0, x} + {1'b0, m} - {1'b0, y};
    end
    return MOD_BITS'(s);
  endfunction

  // multiplier operand select
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = fa;
    mreq.b     = fa;
    unique case (state)
      S_MUL_C: begin
        mreq.start = !launched;
        mreq.b     = t;
      end
      S_MUL_P: begin
        mreq.start = !launched;
      end
      S_MUL_Q: begin
        mreq.start = !launched;
        mreq.a     = fb;
        mreq.b     = fb;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  fmp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mreq),
    .rsp     (mrsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  // sequencer: (a,b) -> (a(2b-a), a^2+b^2), then one step forward on a set bit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            k   <= KBITS'(s_axis_tdata[INDEX_BITS-1:0]) + KBITS'(1);
            pos <= POS_W'(KBITS - 1);
            fa  <= '0;
            fb  <= MOD_BITS'(1);
            if (modulus < MOD_BITS'(2)) begin
              state <= S_DONE;
            end else begin
              state <= S_BIT;
            end
          end
        end
        S_BIT: begin
          // doubling leaves (0,1) unchanged, so a clear bit there is skipped
          if (fa == '0 && fb == MOD_BITS'(1) && !k[pos]) begin
            if (pos == '0) begin
              state <= S_DONE;
            end else begin
              pos <= pos - 1'b1;
            end
          end else begin
            state <= S_DBL;
          end
        end
        S_DBL: begin
          t     <= mod_add(fb, fb, modulus);
          state <= S_SUB;
        end
        S_SUB: begin
          t     <= mod_sub(t, fa, modulus);
          state <= S_MUL_C;
        end
        S_MUL_C: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mrsp.done) begin
            launched <= 1'b0;
            c        <= mrsp.result;
            state    <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mrsp.done) begin
            launched <= 1'b0;
            sq_a     <= mrsp.result;
            state    <= S_MUL_Q;
          end
        end
        S_MUL_Q: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mrsp.done) begin
            launched <= 1'b0;
            sq_b     <= mrsp.result;
            state    <= S_ADD;
          end
        end
        S_ADD: begin
          t     <= mod_add(sq_a, sq_b, modulus);
          state <= S_UPD;
        end
        S_UPD: begin
          if (k[pos]) begin
            fa <= t;
            fb <= mod_add(c, t, modulus);
          end else begin
            fa <= c;
            fb <= t;
          end
          if (pos == '0) begin
            state <= S_DONE;
          end else begin
            pos   <= pos - 1'b1;
            state <= S_BIT;
          end
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_data  <= fa;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_BITS'(out_data);

endmodule

`default_nettype wire

// ===== design/fmp_checker.sv =====
// fmp_checker: port-level assertions for fibonacci_mod_matrix_power_unit,
// bound to the top level; uses fmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmp_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_axis_tvalid,
  input wire logic                                  s_axis_tready,
  input wire logic                                  m_axis_tvalid,
  input wire logic                                  m_axis_tready,
  input wire logic [fmp_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata
);
  import fmp_pkg::*;

  // one item at a time: an accepted beat closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accept");

  // a new result only appears as the sequencer returns to idle
  a_result_with_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while busy");

  // padding above the value is zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_BITS-1:MOD_BITS] == '0)
    else $error("output padding not zero");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // input side closes only on an accepted beat
  a_idle_in: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input closed without a beat");

endmodule

bind fibonacci_mod_matrix_power_unit fmp_checker u_fmp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for fibonacci_mod_matrix_power_unit, sends index
// beats under several modulus settings and checks every fib_value beat
// depends on fmp_pkg and fibonacci_mod_matrix_power_unit
module tb_top;
  import fmp_pkg::*;

  localparam int INDEX_W = INDEX_BITS_DEFAULT;
  localparam int IN_TDATA_W = ((INDEX_W + 7) / 8) * 8;
  localparam int IDLE_PCT = 11;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_PHASES = 7;
  localparam int BEATS_PER_PHASE = 64;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [MOD_BITS-1:0] fib_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [MOD_BITS-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // s_axis_tdata: index, zero padded
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // m_axis_tdata: fib_value, zero padded
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  // bench-side copy of the modulus register and the pending answers
  fib_t modulus_now = MODULUS_RESET;
  fib_t expected_fib[$];
  index_t pending_index[$];
  fib_t fib_want;
  index_t fib_index;
  bit calm = 1'b0;
  bit valid_up = 1'b0;
  int errors = 0;
  int indices_sent = 0;
  int values_checked = 0;
  int modulus_writes = 0;

  always #6 clk = ~clk;

  fibonacci_mod_matrix_power_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // F(idx+1) mod m: square-and-multiply of [[0,1],[1,1]], msb first
  function automatic fib_t fib_mod_predict(input index_t idx, input fib_t m_in);
    longint unsigned m;
    logic [63:0] k;
    longint unsigned r00, r01, r10, r11;
    longint unsigned s00, s01, s10, s11;
    m = m_in;
    k = idx;
    k = k + 64'd1;
    if (m < 2) return '0;
    r00 = 1; r01 = 0; r10 = 0; r11 = 1;
    for (int b = 63; b >= 0; b--) begin
      s00 = ((r00 * r00) % m + (r01 * r10) % m) % m;
      s01 = ((r00 * r01) % m + (r01 * r11) % m) % m;
      s10 = ((r10 * r00) % m + (r11 * r10) % m) % m;
      s11 = ((r10 * r01) % m + (r11 * r11) % m) % m;
      if (k[b]) begin
        // right multiply by the step matrix
        r00 = s01;
        r01 = (s00 + s01) % m;
        r10 = s11;
        r11 = (s10 + s11) % m;
      end else begin
        r00 = s00; r01 = s01; r10 = s10; r11 = s11;
      end
    end
    return fib_t'(r10);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each accepted fib_value beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_fib.size() == 0) begin
        $error("fib_value: no beat expected, actual %0d", m_axis_tdata[MOD_BITS-1:0]);
        errors++;
      end else begin
        fib_want = expected_fib.pop_front();
        fib_index = pending_index.pop_front();
        values_checked++;
        if (m_axis_tdata[MOD_BITS-1:0] !== fib_want) begin
          $error("fib_value (index %0d): expected %0d, actual %0d",
                 fib_index, fib_want, m_axis_tdata[MOD_BITS-1:0]);
          errors++;
        end
      end
    end
  end

  // one index beat, with a random idle gap before it
  task automatic send_index(input index_t idx);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= IN_TDATA_W'(idx);
    if (gap > 0 || !valid_up) s_axis_tvalid <= 1'b1;
    valid_up = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_fib.push_back(fib_mod_predict(idx, modulus_now));
    pending_index.push_back(idx);
    indices_sent++;
  endtask

  // stop the index stream and wait for every pending answer
  task automatic drain_results();
    if (valid_up) s_axis_tvalid <= 1'b0;
    valid_up = 1'b0;
    @(posedge clk);
    while (expected_fib.size() != 0) @(posedge clk);
  endtask

  // modulus register write, only while idle
  task automatic write_modulus(input fib_t value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    modulus_now = value;
    modulus_writes++;
  endtask

  // index extremes and bit patterns under the reset modulus
  task automatic test_reset_modulus();
    index_t picks[10];
    picks = '{index_t'(0), index_t'(1), index_t'(2), index_t'(3), index_t'(10),
              index_t'(90), '1, 62'h2AAA_AAAA_AAAA_AAAA, 62'h1555_5555_5555_5555,
              index_t'(1) << (INDEX_W - 1)};
    foreach (picks[i]) send_index(picks[i]);
    drain_results();
  endtask

  // smallest legal moduli, all ones, and the zero and one moduli
  task automatic test_modulus_extremes();
    fib_t mods[5];
    index_t picks[3];
    mods = '{fib_t'(2), fib_t'(3), '1, fib_t'(0), fib_t'(1)};
    picks = '{index_t'(0), index_t'(1), '1};
    foreach (mods[j]) begin
      write_modulus(mods[j]);
      foreach (picks[i]) send_index(picks[i]);
      drain_results();
    end
  endtask

  // random indices, mostly narrow, a few full width, per modulus setting
  task automatic test_random_indices();
    fib_t m;
    index_t idx;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: m = '1;
        1: m = fib_t'($urandom_range(1000, 2));
        2: m = fib_t'($urandom);
        3: m = fib_t'(2);
        4: m = fib_t'($urandom_range(65535, 2));
        5: m = MODULUS_RESET;
        default: m = fib_t'($urandom);
      endcase
      // one phase runs with no idling on either side
      calm = (phase == 4);
      write_modulus(m);
      repeat (BEATS_PER_PHASE) begin
        idx = index_t'({$urandom, $urandom});
        if ($urandom_range(15) != 0) begin
          idx = idx & ((index_t'(1) << $urandom_range(12, 1)) - index_t'(1));
        end
        send_index(idx);
      end
      drain_results();
    end
    calm = 1'b0;
  endtask

  // reset, tests in turn, then the verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_modulus();
    test_modulus_extremes();
    test_random_indices();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d index beats and %0d compared values over %0d modulus writes",
             indices_sent, values_checked, modulus_writes);
    $display("moduli: reset value, zero, one, two, three, all ones and random widths");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #250_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
